// File: rtl/core/printf_format_argtype_parser_defines.svh
// Assertion macros shared by the parser RTL.
`ifndef PRINTF_FORMAT_ARGTYPE_PARSER_DEFINES_SVH
`define PRINTF_FORMAT_ARGTYPE_PARSER_DEFINES_SVH

// Check that a condition implies a consequence in the same cycle.
`define PFAP_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Check that a condition implies a consequence in the next cycle.
`define PFAP_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/core/pfap_pkg.sv
`default_nettype none
package pfap_pkg;

   // Format string bytes with a fixed meaning
   localparam logic [7:0] CHR_NUL     = 8'h00;
   localparam logic [7:0] CHR_PERCENT = 8'h25;
   localparam logic [7:0] CHR_DOT     = 8'h2E;
   localparam logic [7:0] CHR_STAR    = 8'h2A;
   localparam logic [7:0] CHR_DOLLAR  = 8'h24;
   localparam logic [7:0] CHR_UPPER_L = 8'h4C;
   localparam logic [7:0] CHR_LOWER_L = 8'h6C;
   localparam logic [7:0] CHR_LOWER_H = 8'h68;

   // Argument type codes and modifier flags
   localparam logic [11:0] TYPE_INT     = 12'h000;
   localparam logic [11:0] TYPE_CHAR    = 12'h001;
   localparam logic [11:0] TYPE_STRING  = 12'h003;
   localparam logic [11:0] TYPE_POINTER = 12'h005;
   localparam logic [11:0] TYPE_DOUBLE  = 12'h007;
   localparam logic [11:0] FLAG_LLONG   = 12'h100;
   localparam logic [11:0] FLAG_LONG    = 12'h200;
   localparam logic [11:0] FLAG_SHORT   = 12'h400;
   localparam logic [11:0] FLAG_PTR     = 12'h800;

   // Directive stage bits
   localparam logic [3:0] MASK_FLAGS = 4'h1;
   localparam logic [3:0] MASK_WIDTH = 4'h2;
   localparam logic [3:0] MASK_PREC  = 4'h4;
   localparam logic [3:0] MASK_LEN   = 4'h8;

   // Result kinds
   localparam logic KIND_ARG     = 1'b0;
   localparam logic KIND_SUMMARY = 1'b1;

   localparam logic [15:0] COUNT_MAX      = 16'hFFFF;
   localparam logic [15:0] CAPACITY_RESET = 16'hFFFF;

   typedef struct packed {
      logic        in_directive;
      logic [3:0]  stage_mask;
      logic [11:0] pending_type;
      logic [15:0] arg_count;
   } pfap_state_type;

   typedef struct packed {
      logic        kind;
      logic [15:0] arg_index;
      logic [11:0] arg_type;
      logic [15:0] total_count;
   } pfap_rsp_type;

endpackage
`default_nettype wire

// File: rtl/core/pfap_in_stage.sv
`default_nettype none
module pfap_in_stage (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic [7:0] req_char_code,
   input  wire logic       take,
   output logic            held_valid,
   output logic [7:0]      held_char
);
   logic       valid_ff, valid_in;
   logic [7:0] char_ff;

   // Accept a beat whenever the register is empty or drains this cycle
   assign req_ready = !valid_ff || take;
   assign valid_in  = (req_valid && req_ready) || (valid_ff && !take);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Capture the byte on every accepted beat
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         char_ff <= req_char_code;
      end
   end

   assign held_valid = valid_ff;
   assign held_char  = char_ff;
endmodule
`default_nettype wire

// File: rtl/core/pfap_decode.sv
`default_nettype none
module pfap_decode (
   input  wire logic [7:0]            char_code,
   input  wire pfap_pkg::pfap_state_type cur,
   input  wire logic [15:0]           capacity,
   output pfap_pkg::pfap_state_type   nxt,
   output logic                       emit,
   output pfap_pkg::pfap_rsp_type     rsp
);
   import pfap_pkg::*;

   logic        arg_req;
   logic [11:0] arg_type;
   logic [11:0] t;
   logic [3:0]  s;
   logic        dir;

   // Classify the byte and update the directive state
   always_comb begin
      t        = cur.pending_type;
      s        = cur.stage_mask;
      dir      = cur.in_directive;
      arg_req  = 1'b0;
      arg_type = TYPE_INT;
      if (char_code == CHR_NUL) begin
         dir = 1'b0;
         s   = '0;
         t   = '0;
      end else if (!cur.in_directive) begin
         if (char_code == CHR_PERCENT) begin
            dir = 1'b1;
            s   = '0;
            t   = '0;
         end
      end else begin
         unique case (char_code) inside
            CHR_PERCENT: dir = 1'b0;
            "d", "i", "o", "u", "x", "X": begin
               arg_req  = 1'b1;
               arg_type = t & ~FLAG_LLONG;
               dir      = 1'b0;
            end
            "f", "F", "e", "E", "g", "G", "a", "A": begin
               arg_req  = 1'b1;
               arg_type = ((t & FLAG_LLONG) != '0) ? (FLAG_LLONG | TYPE_DOUBLE) : TYPE_DOUBLE;
               dir      = 1'b0;
            end
            "c": begin
               arg_req  = 1'b1;
               arg_type = TYPE_CHAR;
               dir      = 1'b0;
            end
            "s": begin
               arg_req  = 1'b1;
               arg_type = TYPE_STRING;
               dir      = 1'b0;
            end
            "p": begin
               arg_req  = 1'b1;
               arg_type = TYPE_POINTER;
               dir      = 1'b0;
            end
            "n": begin
               arg_req  = 1'b1;
               arg_type = FLAG_PTR;
               dir      = 1'b0;
            end
            CHR_UPPER_L: begin
               s = s | MASK_LEN;
               t = t | FLAG_LLONG;
            end
            "j", "z", "t": begin
               s = s | MASK_LEN;
               t = t | FLAG_LONG;
            end
            CHR_LOWER_L: begin
               s = s | MASK_LEN;
               t = t | (((t & (FLAG_LONG | FLAG_LLONG)) != '0) ? FLAG_LLONG : FLAG_LONG);
            end
            CHR_LOWER_H: begin
               s = s | MASK_LEN;
               t = ((t & FLAG_SHORT) != '0) ? TYPE_CHAR : (t | FLAG_SHORT);
            end
            ["0":"9"]: begin
               if ((s & MASK_LEN) != '0) begin
                  dir = 1'b0;
               end else if ((s & MASK_PREC) == '0) begin
                  s = s | MASK_WIDTH;
               end
            end
            CHR_DOT: s = s | MASK_PREC;
            "#", "+", "-", "'": begin
               if ((s & (MASK_LEN | MASK_WIDTH | MASK_PREC)) != '0) begin
                  dir = 1'b0;
               end else begin
                  s = s | MASK_FLAGS;
               end
            end
            CHR_DOLLAR: begin
               if ((s & MASK_LEN) != '0 || (s & (MASK_WIDTH | MASK_PREC)) == '0) begin
                  dir = 1'b0;
               end
            end
            CHR_STAR: begin
               if ((s & MASK_LEN) != '0) begin
                  dir = 1'b0;
               end else begin
                  arg_req  = 1'b1;
                  arg_type = TYPE_INT;
               end
            end
            default: dir = 1'b0;
         endcase
      end
   end

   // Count the argument and build the result beat
   always_comb begin
      nxt.in_directive = dir;
      nxt.stage_mask   = s;
      nxt.pending_type = t;
      nxt.arg_count    = cur.arg_count;
      emit             = 1'b0;
      rsp.kind         = KIND_ARG;
      rsp.arg_index    = cur.arg_count;
      rsp.arg_type     = arg_type;
      rsp.total_count  = '0;
      if (char_code == CHR_NUL) begin
         nxt.arg_count   = '0;
         emit            = 1'b1;
         rsp.kind        = KIND_SUMMARY;
         rsp.arg_index   = '0;
         rsp.arg_type    = '0;
         rsp.total_count = cur.arg_count;
      end else if (arg_req) begin
         emit = cur.arg_count < capacity;
         if (cur.arg_count != COUNT_MAX) begin
            nxt.arg_count = cur.arg_count + 16'd1;
         end
      end
   end
endmodule
`default_nettype wire

// File: rtl/core/printf_format_argtype_parser.sv
// Channel  Ports                         Direction  Beat
// req      req_valid/req_ready           in         one format byte (req_char_code)
// rsp      rsp_valid/rsp_ready           out        argument type or end summary
// csr      csr_valid/csr_ready           in         capacity register write
//
// One byte per cycle sustained while rsp_ready holds; a byte sits in the input
// register, and decode loads its result into the result register once that
// register is free or draining. The directive state is registered with the result.
// Reset is synchronous: it clears the parse state and sets capacity to 65535.
// While a result waits, the next byte stays in the input register and the
// request side stalls once that register is full.
`default_nettype none
`include "printf_format_argtype_parser_defines.svh"
module printf_format_argtype_parser (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [7:0]  req_char_code,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic             rsp_kind,
   output logic [15:0]      rsp_arg_index,
   output logic [11:0]      rsp_arg_type,
   output logic [15:0]      rsp_total_count,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [15:0] csr_capacity
);
   import pfap_pkg::*;

   logic           held_valid;
   logic [7:0]     held_char;
   logic           take;
   logic           emit;
   logic           rsp_valid_ff, rsp_valid_in;
   logic [15:0]    capacity_ff;
   pfap_state_type state_ff, state_in;
   pfap_rsp_type   rsp_ff, rsp_in;

   // Decode the held byte when the result register is free or draining
   assign take = held_valid && (!rsp_valid_ff || rsp_ready);

   pfap_in_stage u_in_stage (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_char_code (req_char_code),
      .take          (take),
      .held_valid    (held_valid),
      .held_char     (held_char)
   );

   pfap_decode u_decode (
      .char_code (held_char),
      .cur       (state_ff),
      .capacity  (capacity_ff),
      .nxt       (state_in),
      .emit      (emit),
      .rsp       (rsp_in)
   );

   // Write the capacity register on every config beat
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= CAPACITY_RESET;
      end else if (csr_valid) begin
         capacity_ff <= csr_capacity;
      end
   end

   // Advance the parse state once per decoded byte
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else if (take) begin
         state_ff <= state_in;
      end
   end

   // Load or drop the result beat
   assign rsp_valid_in = take ? emit : (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take && emit) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_kind        = rsp_ff.kind;
   assign rsp_arg_index   = rsp_ff.arg_index;
   assign rsp_arg_type    = rsp_ff.arg_type;
   assign rsp_total_count = rsp_ff.total_count;

   `PFAP_ASSERT_NEXT(a_term_summary, clock, reset, take && held_char == CHR_NUL, rsp_valid_ff && rsp_ff.kind == KIND_SUMMARY && state_ff == '0, "terminator did not yield a summary and clear state")
   `PFAP_ASSERT_NOW(a_summary_fields, clock, reset, rsp_valid_ff && rsp_ff.kind == KIND_SUMMARY, rsp_ff.arg_index == '0 && rsp_ff.arg_type == '0, "summary carries argument fields")
   `PFAP_ASSERT_NOW(a_arg_fields, clock, reset, rsp_valid_ff && rsp_ff.kind == KIND_ARG, rsp_ff.total_count == '0, "argument result carries a count")
   `PFAP_ASSERT_NEXT(a_count_monotone, clock, reset, take && held_char != CHR_NUL, state_ff.arg_count >= $past(state_ff.arg_count), "argument count went down")
   `PFAP_ASSERT_NOW(a_empty_ready, clock, reset, !held_valid, req_ready, "empty input register refused a beat")
endmodule
`default_nettype wire

// File: tb/pfap_arg_checker.sv
`timescale 1ns / 100ps
module pfap_arg_checker (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   input  wire logic        req_ready,
   input  wire logic [7:0]  req_char_code,
   input  wire logic        rsp_valid,
   input  wire logic        rsp_ready,
   input  wire logic        rsp_kind,
   input  wire logic [15:0] rsp_arg_index,
   input  wire logic [11:0] rsp_arg_type,
   input  wire logic [15:0] rsp_total_count,
   input  wire logic        csr_valid,
   input  wire logic        csr_ready,
   input  wire logic [15:0] csr_capacity,
   output int               fail_count,
   output int               awaiting,
   output int               arg_beats,
   output int               end_beats
);
   import pfap_pkg::*;

   // Shadow of the parser state and the capacity register
   logic [15:0]  cap_slots;
   logic         in_dir;
   logic [3:0]   stage_bits;
   logic [11:0]  type_acc;
   logic [15:0]  arg_total;
   pfap_rsp_type awaited_arg_beats[$];

   initial begin
      fail_count = 0;
      awaiting   = 0;
      arg_beats  = 0;
      end_beats  = 0;
   end

   // Work out the result beat, if any, that one format byte causes
   task automatic parse_format_byte(input logic [7:0] c, output logic produced,
                                    output pfap_rsp_type beat);
      logic [11:0] t;
      logic [3:0]  s;
      logic        emit;
      logic [11:0] emit_type;
      produced  = 1'b0;
      beat      = '0;
      emit      = 1'b0;
      emit_type = TYPE_INT;
      t         = type_acc;
      s         = stage_bits;
      if (c == CHR_NUL) begin
         produced         = 1'b1;
         beat.kind        = KIND_SUMMARY;
         beat.total_count = arg_total;
         in_dir           = 1'b0;
         stage_bits       = '0;
         type_acc         = '0;
         arg_total        = '0;
      end else if (!in_dir) begin
         if (c == CHR_PERCENT) begin
            in_dir     = 1'b1;
            type_acc   = '0;
            stage_bits = '0;
         end
      end else begin
         case (c)
            CHR_PERCENT: in_dir = 1'b0;
            "d", "i", "o", "u", "x", "X": begin
               emit      = 1'b1;
               emit_type = t & ~FLAG_LLONG;
               in_dir    = 1'b0;
            end
            "f", "F", "e", "E", "g", "G", "a", "A": begin
               emit      = 1'b1;
               emit_type = ((t & FLAG_LLONG) != '0) ? (FLAG_LLONG | TYPE_DOUBLE) : TYPE_DOUBLE;
               in_dir    = 1'b0;
            end
            "c": begin
               emit      = 1'b1;
               emit_type = TYPE_CHAR;
               in_dir    = 1'b0;
            end
            "s": begin
               emit      = 1'b1;
               emit_type = TYPE_STRING;
               in_dir    = 1'b0;
            end
            "p": begin
               emit      = 1'b1;
               emit_type = TYPE_POINTER;
               in_dir    = 1'b0;
            end
            "n": begin
               emit      = 1'b1;
               emit_type = FLAG_PTR;
               in_dir    = 1'b0;
            end
            CHR_UPPER_L: begin
               s = s | MASK_LEN;
               t = t | FLAG_LLONG;
            end
            "j", "z", "t": begin
               s = s | MASK_LEN;
               t = t | FLAG_LONG;
            end
            CHR_LOWER_L: begin
               s = s | MASK_LEN;
               t = t | (((t & (FLAG_LONG | FLAG_LLONG)) != '0) ? FLAG_LLONG : FLAG_LONG);
            end
            CHR_LOWER_H: begin
               // second h turns short into char, a third adds short again
               s = s | MASK_LEN;
               t = ((t & FLAG_SHORT) != '0) ? TYPE_CHAR : (t | FLAG_SHORT);
            end
            "0", "1", "2", "3", "4", "5", "6", "7", "8", "9": begin
               if ((s & MASK_LEN) != '0)
                  in_dir = 1'b0;
               else if ((s & MASK_PREC) == '0)
                  s = s | MASK_WIDTH;
            end
            CHR_DOT: s = s | MASK_PREC;
            "#", "+", "-", "'": begin
               if ((s & (MASK_LEN | MASK_WIDTH | MASK_PREC)) != '0)
                  in_dir = 1'b0;
               else
                  s = s | MASK_FLAGS;
            end
            CHR_DOLLAR: begin
               if ((s & MASK_LEN) != '0 || (s & (MASK_WIDTH | MASK_PREC)) == '0)
                  in_dir = 1'b0;
            end
            CHR_STAR: begin
               if ((s & MASK_LEN) != '0)
                  in_dir = 1'b0;
               else
                  emit = 1'b1;
            end
            default: in_dir = 1'b0;
         endcase
         type_acc   = t;
         stage_bits = s;
         // count every argument (saturating at COUNT_MAX), report only those inside the capacity
         if (emit) begin
            if (arg_total < cap_slots) begin
               produced       = 1'b1;
               beat.kind      = KIND_ARG;
               beat.arg_index = arg_total;
               beat.arg_type  = emit_type;
            end
            if (arg_total != COUNT_MAX)
               arg_total = arg_total + 16'd1;
         end
      end
   endtask

   task automatic check_field(input string field, input int want, input int got);
      if (want != got) begin
         $display("%0t: %s mismatch: expected %0d, actual %0d", $time, field, want, got);
         fail_count++;
      end
   endtask

   // Compare result beats, track config writes, predict from request beats
   always @(posedge clock) begin : watch
      pfap_rsp_type want;
      pfap_rsp_type made;
      logic         produced;
      if (reset) begin
         cap_slots  = CAPACITY_RESET;
         in_dir     = 1'b0;
         stage_bits = '0;
         type_acc   = '0;
         arg_total  = '0;
         awaited_arg_beats.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (awaited_arg_beats.size() == 0) begin
               $display("%0t: result beat with nothing expected: kind %0d index %0d type %0d count %0d",
                        $time, rsp_kind, rsp_arg_index, rsp_arg_type, rsp_total_count);
               fail_count++;
            end else begin
               want = awaited_arg_beats.pop_front();
               check_field("kind", want.kind, rsp_kind);
               check_field("arg_index", want.arg_index, rsp_arg_index);
               check_field("arg_type", want.arg_type, rsp_arg_type);
               check_field("total_count", want.total_count, rsp_total_count);
               if (rsp_kind == KIND_SUMMARY)
                  end_beats++;
               else
                  arg_beats++;
            end
         end
         if (csr_valid && csr_ready)
            cap_slots = csr_capacity;
         if (req_valid && req_ready) begin
            parse_format_byte(req_char_code, produced, made);
            if (produced)
               awaited_arg_beats.push_back(made);
         end
      end
      awaiting = awaited_arg_beats.size();
   end

endmodule

// File: tb/tb_printf_format_argtype_parser.sv
`timescale 1ns / 100ps
module tb_printf_format_argtype_parser;
   import pfap_pkg::*;

   localparam int WATCHDOG_LIMIT  = 2000;
   localparam int HOLD_OFF_CYCLES = 4;
   localparam int TAIL_CYCLES     = 12;
   localparam int SEGMENT_BYTES   = 315;
   localparam int DRAIN_EVERY     = 8;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [7:0]  req_char_code;
   logic        rsp_valid;
   logic        rsp_ready;
   logic        rsp_kind;
   logic [15:0] rsp_arg_index;
   logic [11:0] rsp_arg_type;
   logic [15:0] rsp_total_count;
   logic        csr_valid;
   logic        csr_ready;
   logic [15:0] csr_capacity;

   int fail_count;
   int awaiting;
   int arg_beats;
   int end_beats;
   int send_idle_pct;
   int rsp_idle_pct;
   int bytes_sent;
   int settings_used;
   int quiet_cycles;

   logic [7:0]  format_bytes[$];
   logic [15:0] capacity_plan[6];
   string flag_chars = "#+-'";
   string conv_chars = "diouxXfFeEgGaAcspn";
   string len_chars  = "hlLjzt";

   printf_format_argtype_parser dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_char_code   (req_char_code),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_kind        (rsp_kind),
      .rsp_arg_index   (rsp_arg_index),
      .rsp_arg_type    (rsp_arg_type),
      .rsp_total_count (rsp_total_count),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_capacity    (csr_capacity)
   );

   pfap_arg_checker checker_i (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_char_code   (req_char_code),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_kind        (rsp_kind),
      .rsp_arg_index   (rsp_arg_index),
      .rsp_arg_type    (rsp_arg_type),
      .rsp_total_count (rsp_total_count),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_capacity    (csr_capacity),
      .fail_count      (fail_count),
      .awaiting        (awaiting),
      .arg_beats       (arg_beats),
      .end_beats       (end_beats)
   );

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   // Stall the result channel at random
   always @(negedge clock) begin
      rsp_ready = ($urandom_range(0, 99) >= rsp_idle_pct);
   end

   // End the run when nothing moves for too long
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no beat accepted for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("tb_printf_format_argtype_parser failed");
            $finish;
         end
      end
   end

   // Present one format byte, idling first at random, and hold until accepted
   task automatic send_byte(input logic [7:0] c);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid     = 1'b1;
      req_char_code = c;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
      @(negedge clock);
      bytes_sent++;
   endtask

   task automatic send_text(input string text);
      for (int i = 0; i < text.len(); i++)
         send_byte(text[i]);
   endtask

   task automatic drain_results();
      req_valid = 1'b0;
      while (awaiting != 0)
         @(negedge clock);
   endtask

   // Write capacity only once the parser has gone quiet
   task automatic write_capacity(input logic [15:0] value);
      drain_results();
      repeat (HOLD_OFF_CYCLES) @(negedge clock);
      csr_valid    = 1'b1;
      csr_capacity = value;
      @(posedge clock);
      while (!csr_ready)
         @(posedge clock);
      @(negedge clock);
      csr_valid = 1'b0;
      settings_used++;
   endtask

   // Append one directive; a broken one gets a stray byte before its conversion
   task automatic add_directive(input bit broken);
      logic [7:0] len_char;
      format_bytes.push_back(CHR_PERCENT);
      repeat ($urandom_range(0, 2))
         format_bytes.push_back(flag_chars[$urandom_range(0, 3)]);
      case ($urandom_range(0, 3))
         1: repeat ($urandom_range(1, 2))
               format_bytes.push_back(8'("0" + $urandom_range(0, 9)));
         2: format_bytes.push_back(CHR_STAR);
         3: begin
            format_bytes.push_back(8'("1" + $urandom_range(0, 8)));
            format_bytes.push_back(CHR_DOLLAR);
            if ($urandom_range(0, 1) == 1)
               format_bytes.push_back(CHR_STAR);
         end
         default: ;
      endcase
      if ($urandom_range(0, 1) == 1) begin
         format_bytes.push_back(CHR_DOT);
         case ($urandom_range(0, 2))
            0: format_bytes.push_back(8'("0" + $urandom_range(0, 9)));
            1: format_bytes.push_back(CHR_STAR);
            default: ;
         endcase
      end
      len_char = len_chars[$urandom_range(0, 5)];
      repeat ($urandom_range(0, 3))
         format_bytes.push_back(len_char);
      if (broken) begin
         case ($urandom_range(0, 4))
            0: format_bytes.push_back(8'($urandom_range(1, 255)));
            1: format_bytes.push_back(8'("0" + $urandom_range(0, 9)));
            2: format_bytes.push_back(CHR_STAR);
            3: format_bytes.push_back(flag_chars[$urandom_range(0, 3)]);
            default: format_bytes.push_back(CHR_DOLLAR);
         endcase
      end
      format_bytes.push_back(conv_chars[$urandom_range(0, conv_chars.len() - 1)]);
   endtask

   initial begin
      int seg_bytes;
      int strings_sent;
      int pick;
      req_valid     = 1'b0;
      req_char_code = '0;
      rsp_ready     = 1'b0;
      csr_valid     = 1'b0;
      csr_capacity  = '0;
      send_idle_pct = 0;
      rsp_idle_pct  = 0;
      bytes_sent    = 0;
      settings_used = 0;
      quiet_cycles  = 0;
      reset         = 1'b1;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed: stray bytes outside a directive, positional width, triple h,
      // flags with width and precision, literal percent, long double, z length
      send_byte(8'hFF);
      send_text("%1$*hhhx%-08.3Lf%%");
      send_byte(8'h80);
      send_text("%zc");
      send_byte(CHR_NUL);

      capacity_plan[0] = 16'd0;
      capacity_plan[1] = 16'd3;
      capacity_plan[2] = CAPACITY_RESET;
      capacity_plan[3] = 16'd1;
      capacity_plan[4] = 16'($urandom_range(2, 8));
      capacity_plan[5] = CAPACITY_RESET;

      // Random format strings over three idle patterns, two capacities each
      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin
               send_idle_pct = 34;
               rsp_idle_pct  = 46;
            end
            1: begin
               send_idle_pct = 46;
               rsp_idle_pct  = 34;
            end
            default: begin
               send_idle_pct = 0;
               rsp_idle_pct  = 0;
            end
         endcase
         for (int slot = 0; slot < 2; slot++) begin
            write_capacity(capacity_plan[2 * phase + slot]);
            seg_bytes    = 0;
            strings_sent = 0;
            while (seg_bytes < SEGMENT_BYTES) begin
               format_bytes.delete();
               repeat ($urandom_range(1, 6)) begin
                  pick = $urandom_range(0, 99);
                  if (pick < 65) begin
                     add_directive(1'b0);
                  end else if (pick < 75) begin
                     format_bytes.push_back(CHR_PERCENT);
                     format_bytes.push_back(CHR_PERCENT);
                  end else if (pick < 90) begin
                     repeat ($urandom_range(1, 4))
                        format_bytes.push_back(8'($urandom_range(1, 255)));
                  end else begin
                     add_directive(1'b1);
                  end
               end
               format_bytes.push_back(CHR_NUL);
               seg_bytes += format_bytes.size();
               foreach (format_bytes[i])
                  send_byte(format_bytes[i]);
               strings_sent++;
               // after every DRAIN_EVERY strings, hold the sender until every result is back
               if (strings_sent % DRAIN_EVERY == 0)
                  drain_results();
            end
         end
      end

      drain_results();
      repeat (TAIL_CYCLES) @(negedge clock);
      $display("Sent %0d format bytes under %0d capacity writes, with and without stalls.",
               bytes_sent, settings_used);
      $display("Checked %0d argument type beats and %0d end-of-string beats.",
               arg_beats, end_beats);
      if (fail_count == 0 && awaiting == 0) begin
         $display("tb_printf_format_argtype_parser passed");
      end else begin
         $display("tb_printf_format_argtype_parser failed");
      end
      $finish;
   end

endmodule

// File: filelist.f
+incdir+rtl/core
rtl/core/pfap_pkg.sv
rtl/core/pfap_in_stage.sv
rtl/core/pfap_decode.sv
rtl/core/printf_format_argtype_parser.sv
tb/pfap_arg_checker.sv
tb/tb_printf_format_argtype_parser.sv
